@@ design/pfb_pkg.sv @@
// Shared types and constants for the page framebuffer I2C flusher.
package pfb_pkg;

  localparam int MAX_COLUMNS_DEF = 128;
  localparam int MAX_PAGES_DEF   = 8;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int CNT_W   = 9;
  localparam int PG_W    = 4;

  localparam logic [7:0] CTRL_CMD     = 8'h80;
  localparam logic [7:0] CTRL_DATA    = 8'hC0;
  localparam logic [7:0] CTRL_LAST    = 8'h40;
  localparam logic [7:0] PAGE_SELECT  = 8'hB0;
  localparam logic [7:0] COL_HIGH_CMD = 8'h10;
  localparam logic [7:0] NIBBLE       = 8'h0F;

  localparam logic [7:0] COLS_RESET  = 8'd128;
  localparam logic [3:0] PAGES_RESET = 4'd8;

  typedef enum logic {
    REG_COLUMNS = 1'b0,
    REG_PAGES   = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    CMD_DRAW  = 2'd0,
    CMD_FLUSH = 2'd1,
    CMD_NEXT  = 2'd2
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW,
    ST_FETCH
  } state_t;

  typedef struct packed {
    logic clear_write;
    logic accept_draw;
    logic accept_flush;
    logic accept_next;
    logic draw_write;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic pixel_ok;
    logic flushing;
    logic out_valid;
  } dpath_status_t;

endpackage

@@ design/pfb_ctrl.sv @@
// Controller state machine for the page framebuffer I2C flusher.
module pfb_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [1:0]            command,
  input  pfb_pkg::dpath_status_t status,
  output logic                  in_stall,
  output pfb_pkg::ctrl_cmd_t    cmd
);
  import pfb_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_CLEAR: begin
        cmd.clear_write = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = status.out_valid;
        if (in_valid && !status.out_valid) begin
          case (command)
            CMD_DRAW: begin
              cmd.accept_draw = 1'b1;
              if (status.pixel_ok) begin
                state_next = ST_DRAW;
              end
            end
            CMD_FLUSH: begin
              cmd.accept_flush = 1'b1;
            end
            CMD_NEXT: begin
              if (status.flushing) begin
                cmd.accept_next = 1'b1;
                state_next      = ST_FETCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DRAW: begin
        cmd.draw_write = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_FETCH: begin
        cmd.load_out = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/pfb_dpath.sv @@
// Datapath: configuration registers, frame store, stream counters and output register.
module pfb_dpath #(
  parameter int MAX_COLUMNS = pfb_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_PAGES   = pfb_pkg::MAX_PAGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pfb_pkg::ctrl_cmd_t          cmd,
  output pfb_pkg::dpath_status_t      status,
  input  logic [6:0]                  pixel_x,
  input  logic [5:0]                  pixel_y,
  input  logic                        pixel_set,
  input  logic                        cfg_write,
  input  logic [pfb_pkg::PADDR_W-1:0] paddr,
  input  logic [pfb_pkg::PDATA_W-1:0] pwdata,
  output logic [pfb_pkg::PDATA_W-1:0] prdata,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [7:0]                  stream_byte,
  output logic                        end_of_transaction,
  output logic                        end_of_frame
);
  import pfb_pkg::*;

  localparam int DEPTH  = MAX_PAGES * MAX_COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [7:0]        columns_in_use;
  logic [3:0]        pages_in_use;
  logic [CNT_W-1:0]  cols_eff;
  logic [PG_W-1:0]   pages_eff;

  logic              flushing;
  logic [PG_W-1:0]   page_counter;
  logic [CNT_W-1:0]  entry;
  logic              odd;

  logic [7:0]        mem [DEPTH];
  logic [7:0]        rdata;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wdata;
  logic              we;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] draw_addr;
  logic [7:0]        draw_mask;
  logic              draw_on;
  logic [ADDR_W-1:0] pixel_addr;
  logic [ADDR_W-1:0] flush_addr;

  logic [7:0]        byte_value;
  logic              eot;
  logic              eof;
  logic [7:0]        hold_byte;
  logic              hold_mem;
  logic              hold_eot;
  logic              hold_eof;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= COLS_RESET;
      pages_in_use   <= PAGES_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(paddr[2]))
        REG_COLUMNS: columns_in_use <= pwdata[7:0];
        REG_PAGES:   pages_in_use   <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index_t'(paddr[2]))
      REG_COLUMNS: prdata = PDATA_W'(columns_in_use);
      REG_PAGES:   prdata = PDATA_W'(pages_in_use);
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    if (columns_in_use == 8'd0) begin
      cols_eff = CNT_W'(1);
    end else if (CNT_W'(columns_in_use) > CNT_W'(MAX_COLUMNS)) begin
      cols_eff = CNT_W'(MAX_COLUMNS);
    end else begin
      cols_eff = CNT_W'(columns_in_use);
    end
    if (pages_in_use == 4'd0) begin
      pages_eff = PG_W'(1);
    end else if ({1'b0, pages_in_use} > 5'(MAX_PAGES)) begin
      pages_eff = PG_W'(MAX_PAGES);
    end else begin
      pages_eff = pages_in_use;
    end
  end

  assign status.pixel_ok = (CNT_W'(pixel_x) < cols_eff) &&
                           ({1'b0, pixel_y[5:3]} < pages_eff);
  assign pixel_addr = ADDR_W'(ADDR_W'(pixel_y[5:3]) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(pixel_x));
  assign flush_addr = ADDR_W'(ADDR_W'(page_counter) * ADDR_W'(MAX_COLUMNS) +
                              ADDR_W'(entry - CNT_W'(3)));

  assign rd_addr = cmd.accept_draw ? pixel_addr : flush_addr;
  assign wr_addr = cmd.clear_write ? clr_addr : draw_addr;
  assign we      = cmd.clear_write || cmd.draw_write;
  assign wdata   = cmd.clear_write ? 8'd0 :
                   (draw_on ? (rdata | draw_mask) : (rdata & ~draw_mask));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_write) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end
  assign status.clear_last = (clr_addr == ADDR_W'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (cmd.accept_draw) begin
      draw_addr <= pixel_addr;
      draw_mask <= 8'd1 << pixel_y[2:0];
      draw_on   <= pixel_set;
    end
  end

  always_comb begin
    if (!odd) begin
      if (entry < CNT_W'(3)) begin
        byte_value = CTRL_CMD;
      end else if (entry < cols_eff + CNT_W'(2)) begin
        byte_value = CTRL_DATA;
      end else begin
        byte_value = CTRL_LAST;
      end
    end else if (entry == CNT_W'(0)) begin
      byte_value = PAGE_SELECT + 8'(page_counter);
    end else if (entry == CNT_W'(1)) begin
      byte_value = 8'h00 & NIBBLE;
    end else begin
      byte_value = COL_HIGH_CMD;
    end
    eot = odd && (entry == cols_eff + CNT_W'(2));
    eof = eot && (page_counter == pages_eff - PG_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      flushing     <= 1'b0;
      page_counter <= '0;
      entry        <= '0;
      odd          <= 1'b0;
    end else if (cmd.accept_flush) begin
      flushing     <= 1'b1;
      page_counter <= '0;
      entry        <= '0;
      odd          <= 1'b0;
    end else if (cmd.accept_next) begin
      if (eof) begin
        flushing     <= 1'b0;
        page_counter <= '0;
        entry        <= '0;
        odd          <= 1'b0;
      end else if (eot) begin
        page_counter <= page_counter + PG_W'(1);
        entry        <= '0;
        odd          <= 1'b0;
      end else if (odd) begin
        entry <= entry + CNT_W'(1);
        odd   <= 1'b0;
      end else begin
        odd <= 1'b1;
      end
    end
  end
  assign status.flushing = flushing;

  always_ff @(posedge clk) begin
    if (cmd.accept_next) begin
      hold_byte <= byte_value;
      hold_mem  <= odd && (entry >= CNT_W'(3));
      hold_eot  <= eot;
      hold_eof  <= eof;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      stream_byte        <= hold_mem ? rdata : hold_byte;
      end_of_transaction <= hold_eot;
      end_of_frame       <= hold_eof;
    end
  end
  assign status.out_valid = out_valid;

endmodule

@@ design/page_framebuffer_i2c_flusher_unit.sv @@
// Top level of the page framebuffer I2C flusher with its APB register port.
// A draw request reads the frame store, then an in-range one writes the modified byte back.
// A next-byte request reads the store on acceptance; ST_FETCH then loads the output register.
// Start-flush and ignored requests stay in ST_IDLE; a new request waits for a pending result.
// After reset a clearing pass zeroes all MAX_PAGES*MAX_COLUMNS store bytes (1024 by default).
// Requests are stalled during that pass; register writes are taken at any time.
module page_framebuffer_i2c_flusher_unit #(
  parameter int MAX_COLUMNS = pfb_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_PAGES   = pfb_pkg::MAX_PAGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pfb_pkg::PADDR_W-1:0] paddr,
  input  logic [pfb_pkg::PDATA_W-1:0] pwdata,
  output logic [pfb_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  command,
  input  logic [6:0]                  pixel_x,
  input  logic [5:0]                  pixel_y,
  input  logic                        pixel_set,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  stream_byte,
  output logic                        end_of_transaction,
  output logic                        end_of_frame
);
  import pfb_pkg::*;

  ctrl_cmd_t     cmd;
  dpath_status_t status;
  logic          cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  pfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  pfb_dpath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_PAGES   (MAX_PAGES)
  ) u_dpath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .pixel_x            (pixel_x),
    .pixel_y            (pixel_y),
    .pixel_set          (pixel_set),
    .cfg_write          (cfg_write),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .stream_byte        (stream_byte),
    .end_of_transaction (end_of_transaction),
    .end_of_frame       (end_of_frame)
  );

endmodule

@@ dv/pfb_stream_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the page framebuffer flusher: predicts the I2C stream and compares results.
module pfb_stream_checker #(
  parameter int MAX_COLUMNS = pfb_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_PAGES   = pfb_pkg::MAX_PAGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pfb_pkg::PADDR_W-1:0] paddr,
  input  logic [pfb_pkg::PDATA_W-1:0] pwdata,
  input  logic                        pready,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  command,
  input  logic [6:0]                  pixel_x,
  input  logic [5:0]                  pixel_y,
  input  logic                        pixel_set,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [7:0]                  stream_byte,
  input  logic                        end_of_transaction,
  input  logic                        end_of_frame,
  output int                          beats_pending,
  output int                          mismatches
);
  import pfb_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       eot;
    logic       eof;
  } stream_beat_t;

  localparam logic [7:0] COL_START = 8'h00;

  logic [7:0]       pixels [MAX_PAGES*MAX_COLUMNS];
  logic             flushing;
  logic [PG_W-1:0]  page_idx;
  logic [CNT_W-1:0] byte_idx;
  logic [7:0]       columns_reg;
  logic [3:0]       pages_reg;
  stream_beat_t     beats_due[$];

  function automatic int active_columns();
    if (columns_reg == 0) return 1;
    if (columns_reg > MAX_COLUMNS) return MAX_COLUMNS;
    return int'(columns_reg);
  endfunction

  function automatic int active_pages();
    if (pages_reg == 0) return 1;
    if (pages_reg > MAX_PAGES) return MAX_PAGES;
    return int'(pages_reg);
  endfunction

  task automatic predict_next_beat();
    int cols;
    int pages;
    int entries;
    int entry;
    stream_beat_t beat;
    cols = active_columns();
    pages = active_pages();
    entries = cols + 3;
    if (page_idx >= pages) page_idx = PG_W'(pages - 1);
    entry = int'(byte_idx >> 1);
    if (entry >= entries) begin
      entry = entries - 1;
      byte_idx = CNT_W'(2 * entries - 1);
    end
    if (!byte_idx[0]) begin
      beat.data = (entry < 3) ? CTRL_CMD : (entry < entries - 1) ? CTRL_DATA : CTRL_LAST;
    end else if (entry == 0) begin
      beat.data = PAGE_SELECT + 8'(page_idx);
    end else if (entry == 1) begin
      beat.data = COL_START & NIBBLE;
    end else if (entry == 2) begin
      beat.data = COL_HIGH_CMD + ((COL_START >> 4) & NIBBLE);
    end else begin
      beat.data = pixels[int'(page_idx) * MAX_COLUMNS + entry - 3];
    end
    beat.eot = (int'(byte_idx) == 2 * entries - 1);
    beat.eof = beat.eot && (int'(page_idx) == pages - 1);
    beats_due.push_back(beat);
    if (beat.eof) begin
      flushing = 1'b0;
      page_idx = '0;
      byte_idx = '0;
    end else if (beat.eot) begin
      page_idx = page_idx + PG_W'(1);
      byte_idx = '0;
    end else begin
      byte_idx = byte_idx + CNT_W'(1);
    end
  endtask

  always @(posedge clk) begin
    int bad;
    int idx;
    logic reg_hit;
    stream_beat_t want;
    bad = 0;
    if (rst) begin
      foreach (pixels[i]) pixels[i] = '0;
      flushing = 1'b0;
      page_idx = '0;
      byte_idx = '0;
      columns_reg = COLS_RESET;
      pages_reg = PAGES_RESET;
      beats_due.delete();
      mismatches <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        reg_hit = 1'b1;
        case (paddr)
          {REG_COLUMNS, 2'b00}: columns_reg = pwdata[7:0];
          {REG_PAGES, 2'b00}: pages_reg = pwdata[3:0];
          default: reg_hit = 1'b0;
        endcase
        if (reg_hit) begin
          flushing = 1'b0;
          page_idx = '0;
          byte_idx = '0;
        end
      end

      if (in_valid && !in_stall) begin
        case (command)
          CMD_DRAW: begin
            if (pixel_x < active_columns() && pixel_y < 8 * active_pages()) begin
              idx = int'(pixel_y >> 3) * MAX_COLUMNS + int'(pixel_x);
              pixels[idx][pixel_y[2:0]] = pixel_set;
            end
          end
          CMD_FLUSH: begin
            flushing = 1'b1;
            page_idx = '0;
            byte_idx = '0;
          end
          CMD_NEXT: begin
            if (flushing) predict_next_beat();
          end
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (beats_due.size() == 0) begin
          $error("stream byte %0h arrived with no request waiting for it", stream_byte);
          bad++;
        end else begin
          want = beats_due.pop_front();
          if (stream_byte !== want.data) begin
            $error("stream_byte: expected %0h, got %0h", want.data, stream_byte);
            bad++;
          end
          if (end_of_transaction !== want.eot) begin
            $error("end_of_transaction: expected %0b, got %0b", want.eot, end_of_transaction);
            bad++;
          end
          if (end_of_frame !== want.eof) begin
            $error("end_of_frame: expected %0b, got %0b", want.eof, end_of_frame);
            bad++;
          end
        end
      end
      mismatches <= mismatches + bad;
    end
    beats_pending <= beats_due.size();
  end

endmodule

@@ dv/page_framebuffer_i2c_flusher_unit_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the page framebuffer flusher: clock, reset, stimulus and verdict.
module page_framebuffer_i2c_flusher_unit_tb;
  import pfb_pkg::*;

  localparam int         ITEM_TARGET = 2000;
  localparam int         PHASE_ITEMS = 200;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           command = CMD_DRAW;
  logic [6:0]           pixel_x = '0;
  logic [5:0]           pixel_y = '0;
  logic                 pixel_set = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           stream_byte;
  logic                 end_of_transaction;
  logic                 end_of_frame;

  int beats_pending;
  int mismatches;
  int items_sent = 0;
  int cols_now = MAX_COLUMNS_DEF;
  int pages_now = MAX_PAGES_DEF;
  bit in_quiet = 1'b0;
  int stall_left = 0;
  int stall_mode_left = 0;
  bit stall_quiet = 1'b0;

  page_framebuffer_i2c_flusher_unit DUT (.*);

  pfb_stream_checker scoreboard (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("page_framebuffer_i2c_flusher_unit regression: fail");
    $finish;
  end

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  always @(posedge clk) begin
    if (stall_mode_left == 0) begin
      stall_quiet <= ($urandom_range(0, 3) == 0);
      stall_mode_left <= $urandom_range(100, 600);
    end else begin
      stall_mode_left <= stall_mode_left - 1;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!stall_quiet && $urandom_range(0, 99) < 25) begin
      out_stall <= 1'b1;
      stall_left <= idle_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send(input logic [1:0] cmd, input logic [6:0] x, input logic [5:0] y,
                      input logic on);
    int gap;
    in_valid <= 1'b1;
    command <= cmd;
    pixel_x <= x;
    pixel_y <= y;
    pixel_set <= on;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    gap = (in_quiet || $urandom_range(0, 99) < 50) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_cmd(input logic [1:0] cmd);
    send(cmd, 7'($urandom), 6'($urandom), 1'($urandom));
  endtask

  task automatic draw_inside();
    send(CMD_DRAW, 7'($urandom_range(0, cols_now - 1)),
         6'($urandom_range(0, pages_now * 8 - 1)), 1'($urandom));
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_cmd(CMD_UNUSED);
      1: send_cmd(CMD_DRAW);
      2: send_cmd(CMD_NEXT);
      default: send_cmd(CMD_FLUSH);
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_display(input logic [7:0] cols, input logic [3:0] pages);
    write_reg(REG_COLUMNS, cols);
    write_reg(REG_PAGES, 8'(pages));
    cols_now = (cols == 0) ? 1 : (cols > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : int'(cols);
    pages_now = (pages == 0) ? 1 : (pages > MAX_PAGES_DEF) ? MAX_PAGES_DEF : int'(pages);
  endtask

  // Draws, one flush, then as many requests as a short frame has bytes, mostly next-byte ones.
  task automatic frame_sequence();
    int beats;
    int r;
    beats = 2 * pages_now * (cols_now + 3);
    if (beats > 300) beats = $urandom_range(40, 300);
    repeat ($urandom_range(0, 12)) draw_inside();
    send_cmd(CMD_FLUSH);
    repeat (beats) begin
      r = $urandom_range(0, 99);
      if (r < 88) send_cmd(CMD_NEXT);
      else if (r < 95) draw_inside();
      else send_noise();
    end
    repeat ($urandom_range(0, 3)) send_cmd(CMD_NEXT);
  endtask

  initial begin
    logic [7:0] col_list [8];
    logic [3:0] page_list [8];
    int phase;
    int phase_start;
    col_list = '{8'd1, 8'd0, 8'd128, 8'd255, 8'd5, 8'd1, 8'd17, 8'd128};
    page_list = '{4'd1, 4'd0, 4'd1, 4'd15, 4'd3, 4'd8, 4'd2, 4'd8};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    set_display(8'd8, 4'd1);

    send(CMD_DRAW, 7'd0, 6'd0, 1'b1);
    send(CMD_DRAW, 7'd7, 6'd7, 1'b1);
    send(CMD_DRAW, 7'd3, 6'd5, 1'b1);
    send(CMD_DRAW, 7'd3, 6'd5, 1'b0);
    send(CMD_DRAW, 7'd8, 6'd0, 1'b1);
    send(CMD_DRAW, 7'd0, 6'd8, 1'b1);
    send(CMD_DRAW, 7'd127, 6'd63, 1'b1);
    send(CMD_UNUSED, 7'd127, 6'd63, 1'b1);
    send(CMD_NEXT, 7'd0, 6'd0, 1'b0);
    send(CMD_FLUSH, 7'd0, 6'd0, 1'b0);
    repeat (6) send(CMD_NEXT, 7'd0, 6'd0, 1'b0);
    // Column 0 has not gone out yet, so the cleared pixel must show in the stream.
    send(CMD_DRAW, 7'd0, 6'd0, 1'b0);
    repeat (3) send(CMD_NEXT, 7'd0, 6'd0, 1'b0);
    send(CMD_FLUSH, 7'd0, 6'd0, 1'b0);
    repeat (3) send(CMD_NEXT, 7'd0, 6'd0, 1'b0);
    drain();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase < 8) set_display(col_list[phase], page_list[phase]);
      else set_display(8'($urandom_range(1, 24)), 4'($urandom_range(1, 4)));
      in_quiet = ($urandom_range(0, 3) == 0);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) frame_sequence();
      drain();
      phase++;
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && beats_pending == 0) begin
      $display("page_framebuffer_i2c_flusher_unit regression: pass");
    end else begin
      $display("page_framebuffer_i2c_flusher_unit regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/pfb_pkg.sv
design/pfb_ctrl.sv
design/pfb_dpath.sv
design/page_framebuffer_i2c_flusher_unit.sv
dv/pfb_stream_checker.sv
dv/page_framebuffer_i2c_flusher_unit_tb.sv
